>>> rtl/core/lane_edge_estimator_defines.svh
// ----------------------------------------------------------------------------
// Lane edge estimator assertion macros
// Shared property forms for the lane edge estimator checks.
// ----------------------------------------------------------------------------
`ifndef LANE_EDGE_ESTIMATOR_DEFINES_SVH
`define LANE_EDGE_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define LEE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lee_pkg.sv
// ----------------------------------------------------------------------------
// Lane edge estimator package
// Types, constants and helpers shared by the lane edge estimator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lee_pkg;

  localparam int unsigned MAX_SEGMENTS = 20;
  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned SEEN_W       = 7;
  localparam int unsigned Q_FRAC       = 16;
  localparam int unsigned OPA_W        = 41;
  localparam int unsigned OPB_W        = 27;
  localparam int unsigned MAG_W        = 26;
  localparam int unsigned QUO_W        = 40;
  localparam int unsigned ACC_W        = 67;
  localparam int unsigned CNT_W        = 6;

  localparam logic [8:0]  CENTER_ROW_RST = 9'd60;
  localparam logic [9:0]  LANE_WIDTH_RST = 10'd640;
  localparam logic [23:0] SLOPE_THR_RST  = 24'd26214;
  localparam logic [9:0]  IMG_CENTER_RST = 10'd320;

  localparam logic signed [OPB_W-1:0] VERT_SLOPE = OPB_W'(999 * 65536);
  localparam logic signed [OPB_W-1:0] STEER_DIV  = OPB_W'(6);
  localparam logic signed [OPA_W-1:0] STEER_BIAS = OPA_W'(45);

  typedef enum logic [1:0] {
    KIND_SEG     = 2'd0,
    KIND_SEG_END = 2'd1,
    KIND_END     = 2'd2,
    KIND_NONE    = 2'd3
  } lee_kind_e;

  typedef enum logic [1:0] {
    CFG_CENTER_ROW = 2'd0,
    CFG_LANE_WIDTH = 2'd1,
    CFG_SLOPE_THR  = 2'd2,
    CFG_IMG_CENTER = 2'd3
  } lee_cfg_e;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } lee_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG_DIV,
    ST_CLASSIFY,
    ST_GRP,
    ST_M,
    ST_MX,
    ST_MY,
    ST_MUL,
    ST_X,
    ST_COMBINE,
    ST_STEER,
    ST_EMIT
  } lee_state_e;

  typedef struct packed {
    lee_kind_e  kind;
    logic [9:0] x_start;
    logic [8:0] y_start;
    logic [9:0] x_end;
    logic [8:0] y_end;
  } lee_in_t;

  typedef struct packed {
    logic signed [15:0] left_edge;
    logic signed [15:0] right_edge;
    logic signed [15:0] lane_midpoint;
    logic signed [15:0] steering_value;
  } lee_out_t;

  typedef struct packed {
    logic                    start;
    lee_op_e                 op;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } lee_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [OPA_W-1:0] res;
  } lee_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [OPA_W-1:0] v);
    logic signed [15:0] r;
    if (v > OPA_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -OPA_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/lee_iter_unit.sv
// ----------------------------------------------------------------------------
// Lane edge estimator iterative unit
// Signed divide (one quotient bit a cycle) and signed multiply with a Q.16
// scale (one multiplier bit a cycle) on one shared accumulator register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lee_iter_unit import lee_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lee_req_t req_i,
  output lee_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  lee_op_e          op_q, op_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [MAG_W-1:0] dvs_q, dvs_d;
  logic [MAG_W-1:0] mcand_q, mcand_d;

  logic [OPA_W-1:0] a_mag;
  logic [OPB_W-1:0] b_mag;
  logic [MAG_W:0]   sh_rem;
  logic [MAG_W+1:0] diff;
  logic [MAG_W:0]   add;
  logic [ACC_W-1:0] acc_div;
  logic [ACC_W-1:0] acc_mul;
  logic [OPA_W-1:0] mag;

  always_comb begin
    a_mag = req_i.a[OPA_W-1] ? OPA_W'(-req_i.a) : OPA_W'(req_i.a);
    b_mag = req_i.b[OPB_W-1] ? OPB_W'(-req_i.b) : OPB_W'(req_i.b);

    sh_rem  = {acc_q[ACC_W-2:QUO_W], acc_q[QUO_W-1]};
    diff    = {1'b0, sh_rem} - {2'b00, dvs_q};
    acc_div = {(diff[MAG_W+1] ? sh_rem : diff[MAG_W:0]), acc_q[QUO_W-2:0], ~diff[MAG_W+1]};

    add     = acc_q[2*MAG_W:MAG_W] + {1'b0, mcand_q};
    acc_mul = {14'd0, 1'b0, (acc_q[0] ? add : acc_q[2*MAG_W:MAG_W]), acc_q[MAG_W-1:1]};

    mag = (op_q == OP_DIV) ? {1'b0, acc_q[QUO_W-1:0]} : {5'd0, acc_q[2*MAG_W-1:Q_FRAC]};

    busy_d  = busy_q;
    done_d  = 1'b0;
    op_d    = op_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    dvs_d   = dvs_q;
    mcand_d = mcand_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      neg_d  = req_i.a[OPA_W-1] ^ req_i.b[OPB_W-1];
      dvs_d  = b_mag[MAG_W-1:0];
      if (req_i.op == OP_DIV) begin
        acc_d = {27'd0, a_mag[QUO_W-1:0]};
        cnt_d = CNT_W'(QUO_W - 1);
      end else begin
        acc_d   = {41'd0, b_mag[MAG_W-1:0]};
        mcand_d = a_mag[MAG_W-1:0];
        cnt_d   = CNT_W'(MAG_W - 1);
      end
    end else if (busy_q) begin
      acc_d = (op_q == OP_DIV) ? acc_div : acc_mul;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    neg_q   <= neg_d;
    cnt_q   <= cnt_d;
    acc_q   <= acc_d;
    dvs_q   <= dvs_d;
    mcand_q <= mcand_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? OPA_W'(-$signed(mag)) : $signed(mag);

endmodule

>>> rtl/core/lane_edge_estimator.sv
// Takes the line segments of a frame one transfer at a time and, at frame end,
// delivers the left and right lane edge columns at center_row, their midpoint
// and a steering value. A segment occupies the block for its slope division in
// the shared unit and its classification; a vertical segment skips the
// division, and segments past the per-frame limit are neither divided nor
// classified. At frame end, per group, up to four divisions (average slope,
// mean x, mean y, edge column) and a multiply run, then one division for the
// steering value, all in the one shared divide/multiply unit, plus any wait
// for the output register to free up. Input ready is high only while the
// block is idle.
// ----------------------------------------------------------------------------
// Lane edge estimator
// Segment classification, per-group sums and frame-end edge solve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lane_edge_estimator_defines.svh"

module lane_edge_estimator import lee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lee_in_t     in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lee_out_t    out_o
);

  lee_state_e state_q, state_d;
  lee_req_t   req;
  lee_rsp_t   rsp;

  logic [8:0]  cr_q;
  logic [9:0]  lw_q;
  logic [23:0] thr_q;
  logic [9:0]  icx_q;

  lee_in_t                 seg_q, seg_d;
  logic                    grp_q, grp_d;
  logic [SEEN_W-1:0]       seen_q, seen_d;
  logic [SEEN_W-1:0]       cnt_q [2];
  logic [SEEN_W-1:0]       cnt_d [2];
  logic [16:0]             sx_q [2];
  logic [16:0]             sx_d [2];
  logic [16:0]             sy_q [2];
  logic [16:0]             sy_d [2];
  logic signed [39:0]      ss_q [2];
  logic signed [39:0]      ss_d [2];
  logic signed [15:0]      edge_q [2];
  logic signed [15:0]      edge_d [2];
  logic                    have_q [2];
  logic                    have_d [2];
  logic signed [15:0]      last_l_q, last_l_d, last_r_q, last_r_d;
  logic signed [OPB_W-1:0] s_q, s_d, m_q, m_d;
  logic                    vert_q, vert_d;
  logic signed [OPA_W-1:0] mx_q, mx_d, my_q, my_d;
  logic signed [15:0]      mid_q, mid_d;
  lee_out_t                out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic signed [10:0]      dx;
  logic signed [9:0]       dy;
  logic [OPB_W-1:0]        s_mag;
  logic                    keep;
  logic signed [15:0]      xl, xr;
  logic signed [16:0]      pair_sum;
  logic signed [16:0]      pair_half;
  logic [SEEN_W-1:0]       n_sel;

  lee_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q  <= CENTER_ROW_RST;
      lw_q  <= LANE_WIDTH_RST;
      thr_q <= SLOPE_THR_RST;
      icx_q <= IMG_CENTER_RST;
    end else if (cfg_we_i) begin
      case (lee_cfg_e'(cfg_idx_i))
        CFG_CENTER_ROW: cr_q  <= cfg_data_i[8:0];
        CFG_LANE_WIDTH: lw_q  <= cfg_data_i[9:0];
        CFG_SLOPE_THR:  thr_q <= cfg_data_i;
        CFG_IMG_CENTER: icx_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dx    = $signed({1'b0, seg_q.x_end}) - $signed({1'b0, seg_q.x_start});
    dy    = $signed({1'b0, seg_q.y_end}) - $signed({1'b0, seg_q.y_start});
    s_mag = s_q[OPB_W-1] ? OPB_W'(-s_q) : OPB_W'(s_q);
    keep  = s_mag > {3'd0, thr_q};
    n_sel = cnt_q[grp_q];

    if (!have_q[0] && !have_q[1]) begin
      xl = last_l_q;
      xr = last_r_q;
    end else if (!have_q[0]) begin
      xr = edge_q[1];
      xl = sat16(OPA_W'(edge_q[1]) - $signed({31'd0, lw_q}));
    end else if (!have_q[1]) begin
      xl = edge_q[0];
      xr = sat16(OPA_W'(edge_q[0]) + $signed({31'd0, lw_q}));
    end else begin
      xl = edge_q[0];
      xr = edge_q[1];
    end
    pair_sum  = 17'(xl) + 17'(xr);
    pair_half = (pair_sum + $signed({16'd0, pair_sum[16]})) >>> 1;

    state_d     = state_q;
    seg_d       = seg_q;
    grp_d       = grp_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    ss_d        = ss_q;
    edge_d      = edge_q;
    have_d      = have_q;
    last_l_d    = last_l_q;
    last_r_d    = last_r_q;
    s_d         = s_q;
    m_d         = m_q;
    vert_d      = vert_q;
    mx_d        = mx_q;
    my_d        = my_q;
    mid_d       = mid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    req         = '0;
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          seg_d     = in_i;
          grp_d     = 1'b0;
          have_d[0] = 1'b0;
          have_d[1] = 1'b0;
          case (in_i.kind)
            KIND_SEG, KIND_SEG_END: begin
              if (seen_q < SEEN_W'(MAX_SEGMENTS)) begin
                seen_d  = seen_q + 1'b1;
                state_d = ST_SEG_DIV;
              end else if (in_i.kind == KIND_SEG_END) begin
                state_d = ST_GRP;
              end
            end
            KIND_END: state_d = ST_GRP;
            default: ;
          endcase
        end
      end
      ST_SEG_DIV: begin
        if (dx == '0) begin
          s_d     = VERT_SLOPE;
          vert_d  = 1'b1;
          state_d = ST_CLASSIFY;
        end else if (rsp.done) begin
          s_d     = rsp.res[OPB_W-1:0];
          vert_d  = 1'b0;
          state_d = ST_CLASSIFY;
        end else if (!rsp.busy) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = {{15{dy[9]}}, dy, 16'd0};
          req.b     = {{16{dx[10]}}, dx};
        end
      end
      ST_CLASSIFY: begin
        if (keep && s_q < 0 && seg_q.x_end < icx_q) begin
          cnt_d[0] = cnt_q[0] + 1'b1;
          sx_d[0]  = sx_q[0] + 17'(seg_q.x_start) + 17'(seg_q.x_end);
          sy_d[0]  = sy_q[0] + 17'(seg_q.y_start) + 17'(seg_q.y_end);
          ss_d[0]  = ss_q[0] + (vert_q ? 40'sd0 : 40'(s_q));
        end else if (keep && s_q > 0 && seg_q.x_start > icx_q) begin
          cnt_d[1] = cnt_q[1] + 1'b1;
          sx_d[1]  = sx_q[1] + 17'(seg_q.x_start) + 17'(seg_q.x_end);
          sy_d[1]  = sy_q[1] + 17'(seg_q.y_start) + 17'(seg_q.y_end);
          ss_d[1]  = ss_q[1] + (vert_q ? 40'sd0 : 40'(s_q));
        end
        state_d = (seg_q.kind == KIND_SEG_END) ? ST_GRP : ST_IDLE;
      end
      ST_GRP: begin
        if (n_sel == '0) begin
          grp_d   = 1'b1;
          state_d = grp_q ? ST_COMBINE : ST_GRP;
        end else begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = OPA_W'(ss_q[grp_q]);
          req.b     = {20'd0, n_sel};
          state_d   = ST_M;
        end
      end
      ST_M: begin
        if (rsp.done) begin
          if (rsp.res == '0) begin
            grp_d   = 1'b1;
            state_d = grp_q ? ST_COMBINE : ST_GRP;
          end else begin
            m_d       = rsp.res[OPB_W-1:0];
            req.start = 1'b1;
            req.op    = OP_DIV;
            req.a     = {8'd0, sx_q[grp_q], 16'd0};
            req.b     = {19'd0, n_sel, 1'b0};
            state_d   = ST_MX;
          end
        end
      end
      ST_MX: begin
        if (rsp.done) begin
          mx_d      = rsp.res;
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = {8'd0, sy_q[grp_q], 16'd0};
          req.b     = {19'd0, n_sel, 1'b0};
          state_d   = ST_MY;
        end
      end
      ST_MY: begin
        if (rsp.done) begin
          my_d      = rsp.res;
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = mx_q;
          req.b     = m_q;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_DIV;
          req.a     = $signed({16'd0, cr_q, 16'd0}) - (my_q - rsp.res);
          req.b     = m_q;
          state_d   = ST_X;
        end
      end
      ST_X: begin
        if (rsp.done) begin
          edge_d[grp_q] = sat16(rsp.res);
          have_d[grp_q] = 1'b1;
          grp_d         = 1'b1;
          state_d       = grp_q ? ST_COMBINE : ST_GRP;
        end
      end
      ST_COMBINE: begin
        last_l_d  = xl;
        last_r_d  = xr;
        edge_d[0] = xl;
        edge_d[1] = xr;
        have_d[0] = 1'b1;
        have_d[1] = 1'b1;
        mid_d     = pair_half[15:0];
        seen_d    = '0;
        for (int g = 0; g < 2; g++) begin
          cnt_d[g] = '0;
          sx_d[g]  = '0;
          sy_d[g]  = '0;
          ss_d[g]  = '0;
        end
        req.start = 1'b1;
        req.op    = OP_DIV;
        req.a     = OPA_W'($signed(pair_half[15:0])) - $signed({31'd0, icx_q});
        req.b     = STEER_DIV;
        state_d   = ST_STEER;
      end
      ST_STEER: begin
        if (rsp.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.steering_value = sat16(rsp.res + STEER_BIAS);
          out_d.left_edge      = edge_q[0];
          out_d.right_edge     = edge_q[1];
          out_d.lane_midpoint  = mid_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      last_l_q    <= '0;
      last_r_q    <= 16'(FRAME_WIDTH);
      for (int g = 0; g < 2; g++) begin
        cnt_q[g] <= '0;
        sx_q[g]  <= '0;
        sy_q[g]  <= '0;
        ss_q[g]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
      last_l_q    <= last_l_d;
      last_r_q    <= last_r_d;
      cnt_q       <= cnt_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      ss_q        <= ss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q  <= seg_d;
    grp_q  <= grp_d;
    edge_q <= edge_d;
    have_q <= have_d;
    s_q    <= s_d;
    m_q    <= m_d;
    vert_q <= vert_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    mid_q  <= mid_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LEE_ASSERT_NEXT(a_busy_after_take,
    in_valid_i && in_ready_o && in_i.kind != KIND_NONE && seen_q < SEEN_W'(MAX_SEGMENTS),
    !in_ready_o, "block still ready after taking a segment")
  `LEE_ASSERT_SAME(a_done_in_wait, rsp.done,
    state_q == ST_SEG_DIV || state_q == ST_M || state_q == ST_MX || state_q == ST_MY ||
    state_q == ST_MUL || state_q == ST_X || state_q == ST_STEER,
    "unit result arrived outside a wait state")
  `LEE_ASSERT_SAME(a_seen_bound, 1'b1, seen_q <= SEEN_W'(MAX_SEGMENTS),
    "segment count past frame limit")

endmodule

>>> test/tb_lane_edge_estimator.sv
// ----------------------------------------------------------------------------
// Lane edge estimator testbench
// Drives directed and random segment frames under random idle gaps on both
// channels and compares every frame-end result with a cycle-free model of the
// edge solve or a row's own expected value, across several register sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lane_edge_estimator;
  import lee_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5000000;

  typedef struct {
    lee_in_t  item;
    bit       has_exp;
    lee_out_t exp_out;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  lee_in_t     in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  lee_out_t    out_o;

  longint      reg_center_row, reg_lane_width, reg_slope_thr, reg_img_center;
  longint      seen_cnt, lcnt, rcnt, lsx, lsy, rsx, rsy, lss, rss;
  longint      prev_left, prev_right;
  lee_out_t    edge_q[$];
  lee_out_t    typed_q[$];
  bit          typed_flag_q[$];
  int unsigned err_cnt = 0;
  int unsigned cyc_cnt = 0;
  bit          rx_stall_mode = 1'b1;

  lane_edge_estimator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 4);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc_cnt);
    err_cnt++;
  endtask

  task automatic clear_sums();
    seen_cnt = 0; lcnt = 0; rcnt = 0;
    lsx = 0; lsy = 0; rsx = 0; rsy = 0; lss = 0; rss = 0;
  endtask

  function automatic bit solve_group(longint n, longint sx, longint sy, longint ss,
                                     output longint x);
    longint m, mx, my, b;
    x = 0;
    if (n == 0) return 0;
    m = ss / n;
    if (m == 0) return 0;
    mx = (sx * 65536) / (2 * n);
    my = (sy * 65536) / (2 * n);
    b = my - (m * mx) / 65536;
    x = clamp16((reg_center_row * 65536 - b) / m);
    return 1;
  endfunction

  task automatic predict_edges(lee_in_t it);
    longint xs, ys, xe, ye, dx, dy, s, mag, xl, xr, mid;
    bit hl, hr;
    lee_out_t r;
    xs = it.x_start; ys = it.y_start; xe = it.x_end; ye = it.y_end;
    if (it.kind == KIND_NONE) return;
    if (it.kind != KIND_END && seen_cnt < MAX_SEGMENTS) begin
      seen_cnt++;
      dx = xe - xs;
      dy = ye - ys;
      s = (dx == 0) ? 999 * 65536 : (dy * 65536) / dx;
      mag = s < 0 ? -s : s;
      if (mag > reg_slope_thr) begin
        if (s < 0 && xe < reg_img_center) begin
          lcnt++; lsx += xs + xe; lsy += ys + ye; lss += (dx == 0) ? 0 : s;
        end else if (s > 0 && xs > reg_img_center) begin
          rcnt++; rsx += xs + xe; rsy += ys + ye; rss += (dx == 0) ? 0 : s;
        end
      end
    end
    if (it.kind == KIND_SEG) return;
    hl = solve_group(lcnt, lsx, lsy, lss, xl);
    hr = solve_group(rcnt, rsx, rsy, rss, xr);
    if (!hl && !hr) begin
      xl = prev_left; xr = prev_right;
    end else if (!hl) begin
      xl = clamp16(xr - reg_lane_width);
    end else if (!hr) begin
      xr = clamp16(xl + reg_lane_width);
    end
    prev_left = xl; prev_right = xr;
    clear_sums();
    mid = (xl + xr) / 2;
    r.left_edge = xl[15:0];
    r.right_edge = xr[15:0];
    r.lane_midpoint = mid[15:0];
    r.steering_value = 16'(clamp16((mid - reg_img_center) / 6 + 45));
    edge_q.insert(edge_q.size(), r);
  endtask

  task automatic send_item(stim_row_t row);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_i <= row.item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_edges(row.item);
    if (row.item.kind inside {KIND_SEG_END, KIND_END}) begin
      typed_flag_q.insert(typed_flag_q.size(), row.has_exp);
      typed_q.insert(typed_q.size(), row.exp_out);
    end
  endtask

  task automatic write_reg(lee_cfg_e idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 24'(val);
    @(posedge clk_i);
    case (idx)
      CFG_CENTER_ROW: reg_center_row = val;
      CFG_LANE_WIDTH: reg_lane_width = val;
      CFG_SLOPE_THR:  reg_slope_thr = val;
      default:        reg_img_center = val;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic stim_row_t mk(lee_kind_e k, int xs, int ys, int xe, int ye);
    stim_row_t r;
    r.item = '{kind: k, x_start: 10'(xs), y_start: 9'(ys), x_end: 10'(xe), y_end: 9'(ye)};
    r.has_exp = 0;
    r.exp_out = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_exp(lee_kind_e k, int l, int rt, int md, int st);
    stim_row_t r;
    r = mk(k, 0, 0, 0, 0);
    r.has_exp = 1;
    r.exp_out = '{left_edge: 16'(l), right_edge: 16'(rt),
                  lane_midpoint: 16'(md), steering_value: 16'(st)};
    return r;
  endfunction

  function automatic stim_row_t rand_seg(bit ends);
    stim_row_t r;
    int unsigned xs, xe;
    r = mk(ends ? KIND_SEG_END : KIND_SEG, 0, 0, 0, 0);
    case ($urandom_range(0, 3))
      0: begin xs = $urandom_range(0, 300); xe = xs + $urandom_range(1, 19); end
      1: begin xs = $urandom_range(340, 620); xe = xs + $urandom_range(1, 19); end
      2: begin xs = $urandom_range(0, 639); xe = xs; end
      default: begin xs = $urandom_range(0, 639); xe = $urandom_range(0, 639); end
    endcase
    r.item.x_start = 10'(xs);
    r.item.x_end = 10'(xe > 639 ? 639 : xe);
    r.item.y_start = 9'($urandom_range(0, 479));
    r.item.y_end = 9'($urandom_range(0, 479));
    if ($urandom_range(0, 15) == 0) r.item.kind = KIND_NONE;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rx_stall_mode) out_ready_i <= ($urandom_range(0, 4) != 0);
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    lee_out_t want;
    bit typed;
    lee_out_t tv;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (edge_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = edge_q.pop_front();
        typed = typed_flag_q.pop_front();
        tv = typed_q.pop_front();
        if (typed) want = tv;
        if (out_o.left_edge !== want.left_edge)
          report_mismatch("left_edge", out_o.left_edge, want.left_edge);
        if (out_o.right_edge !== want.right_edge)
          report_mismatch("right_edge", out_o.right_edge, want.right_edge);
        if (out_o.lane_midpoint !== want.lane_midpoint)
          report_mismatch("lane_midpoint", out_o.lane_midpoint, want.lane_midpoint);
        if (out_o.steering_value !== want.steering_value)
          report_mismatch("steering_value", out_o.steering_value, want.steering_value);
      end
    end
  end

  initial begin
    stim_row_t directed[$];
    int frame_len;
    reg_center_row = 60; reg_lane_width = 640; reg_slope_thr = 26214; reg_img_center = 320;
    clear_sums();
    prev_left = 0; prev_right = FRAME_WIDTH;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: previous edges 0 and 640, mid 320, steer 45
    directed.insert(directed.size(), mk_exp(KIND_END, 0, 640, 320, 45));
    directed.insert(directed.size(), mk(KIND_SEG, 100, 400, 200, 300));
    directed.insert(directed.size(), mk(KIND_SEG, 0, 479, 310, 0));
    directed.insert(directed.size(), mk(KIND_SEG, 400, 100, 600, 400));
    directed.insert(directed.size(), mk(KIND_SEG, 639, 0, 639, 479));
    directed.insert(directed.size(), mk(KIND_SEG, 10, 10, 300, 11));
    directed.insert(directed.size(), mk(KIND_SEG_END, 500, 479, 639, 479));
    directed.insert(directed.size(), mk(KIND_SEG, 100, 479, 300, 0));
    directed.insert(directed.size(), mk(KIND_END, 0, 0, 0, 0));
    directed.insert(directed.size(), mk(KIND_SEG_END, 400, 0, 639, 479));
    directed.insert(directed.size(), mk(KIND_NONE, 639, 479, 639, 479));
    directed.insert(directed.size(), mk(KIND_SEG, 200, 200, 200, 300));
    directed.insert(directed.size(), mk(KIND_END, 0, 0, 0, 0));
    for (int i = 0; i < 22; i++)
      directed.insert(directed.size(), mk(KIND_SEG, 0, 479, 100, 0));
    directed.insert(directed.size(), mk(KIND_SEG_END, 400, 0, 500, 479));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_CENTER_ROW, 0); write_reg(CFG_LANE_WIDTH, 0);
          write_reg(CFG_SLOPE_THR, 0); write_reg(CFG_IMG_CENTER, 0);
        end
        1: begin
          write_reg(CFG_CENTER_ROW, 479); write_reg(CFG_LANE_WIDTH, 1023);
          write_reg(CFG_SLOPE_THR, 16777215); write_reg(CFG_IMG_CENTER, 1023);
        end
        2: begin
          write_reg(CFG_CENTER_ROW, 240); write_reg(CFG_LANE_WIDTH, 500);
          write_reg(CFG_SLOPE_THR, 65536); write_reg(CFG_IMG_CENTER, 320);
        end
        3: begin
          write_reg(CFG_CENTER_ROW, $urandom_range(0, 479));
          write_reg(CFG_LANE_WIDTH, $urandom_range(0, 1023));
          write_reg(CFG_SLOPE_THR, $urandom_range(0, 200000));
          write_reg(CFG_IMG_CENTER, $urandom_range(0, 1023));
        end
        default: begin
          write_reg(CFG_CENTER_ROW, 60); write_reg(CFG_LANE_WIDTH, 640);
          write_reg(CFG_SLOPE_THR, 26214); write_reg(CFG_IMG_CENTER, 320);
        end
      endcase
      cfg_we_i <= 1'b0;
      rx_stall_mode = (phase != 2);
      for (int n = 0; n < 400; n += frame_len) begin
        frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 26)
                                                : $urandom_range(1, 8);
        for (int k = 0; k < frame_len - 1; k++) send_item(rand_seg(0));
        if ($urandom_range(0, 3) == 0) begin
          send_item(rand_seg(0));
          send_item(mk(KIND_END, $urandom_range(0, 1023), $urandom_range(0, 511),
                       $urandom_range(0, 1023), $urandom_range(0, 511)));
        end else begin
          send_item(rand_seg(1));
        end
      end
      // raw random payloads so every input bit toggles; always ended properly
      send_item(mk(lee_kind_e'(2'($urandom_range(0, 3))), $urandom_range(0, 1023),
                   $urandom_range(0, 511), $urandom_range(0, 1023), $urandom_range(0, 511)));
      send_item(mk(KIND_END, 0, 0, 0, 0));
      drain();
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lee_pkg.sv
rtl/core/lee_iter_unit.sv
rtl/core/lane_edge_estimator.sv
test/tb_lane_edge_estimator.sv
